// ----- sv/tun_pkg.sv -----
package tun_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned LIMIT_W = 34;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] cz;
  } tri_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] norm_x;
    logic signed [FIELD_W-1:0] norm_y;
    logic signed [FIELD_W-1:0] norm_z;
    logic                      degenerate;
  } tri_out_t;

endpackage

// ----- sv/tun_sqrt_cell.sv -----
module tun_sqrt_cell #(
  parameter int unsigned RW = 35,
  parameter int unsigned PW = 105
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  output logic [2*RW-1:0] rad_o,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);
  import tun_pkg::*;

  logic [RW+2:0] trial_rem;
  logic [RW+2:0] trial_sub;
  logic          take;
  logic          valid_q;
  logic [2*RW-1:0] rad_q;
  logic [RW:0]   rem_q;
  logic [RW-1:0] root_q;
  logic [PW-1:0] pay_q;

  // One root bit per cell: bring down two radicand bits, try root*4+1.
  always_comb begin
    trial_rem = {rem_i, rad_i[2*RW-1:2*RW-2]};
    trial_sub = (RW+3)'({root_i, 2'b01});
    take      = (trial_rem >= trial_sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= take ? (RW+1)'(trial_rem - trial_sub) : trial_rem[RW:0];
      root_q <= {root_i[RW-2:0], take};
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

// ----- sv/tun_div_cell.sv -----
module tun_div_cell #(
  parameter int unsigned LW = 35,
  parameter int unsigned QW = 15,
  parameter int unsigned PW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [LW-1:0] len_i,
  input  logic [LW:0]   rem_i [3],
  input  logic [QW-1:0] quo_i [3],
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [LW-1:0] len_o,
  output logic [LW:0]   rem_o [3],
  output logic [QW-1:0] quo_o [3],
  output logic [PW-1:0] pay_o
);
  import tun_pkg::*;

  logic          valid_q;
  logic [LW-1:0] len_q;
  logic [LW:0]   rem_q [3];
  logic [QW-1:0] quo_q [3];
  logic [PW-1:0] pay_q;
  logic [LW:0]   rem_d [3];
  logic [2:0]    bit_d;

  // One quotient bit per lane; the partial remainder stays below twice the length.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bit_d[k] = (rem_i[k] >= (LW+1)'(len_i));
      rem_d[k] = bit_d[k] ? (rem_i[k] - (LW+1)'(len_i)) : rem_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= len_i;
      pay_q <= pay_i;
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= rem_d[k] << 1;
        quo_q[k] <= {quo_i[k][QW-2:0], bit_d[k]};
      end
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign pay_o   = pay_q;

endmodule

// ----- sv/triangle_unit_normal.sv -----
// Throughput: one triangle per cycle while the skid stage is empty;
// set by the root cell row and the divider cell row,
// each handing one item to the next cell every cycle.
// Up to two results are held at the output (output register plus skid stage).
// Reset is asynchronous, active low: all valid flags clear and the limit returns to 1.
// Data registers are not reset.
module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tun_pkg::tri_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tun_pkg::tri_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tun_pkg::LIMIT_W-1:0]   cfg_data_i
);
  import tun_pkg::*;

  // Width ladder: coordinates, edge vectors, products, cross product,
  // magnitudes, squares, the sum of squares and its root.
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned FB   = NORMAL_FRAC_BITS;
  localparam int unsigned EW   = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned PRW  = 2 * DW;
  localparam int unsigned NW   = PRW + 1;
  localparam int unsigned MW   = NW - 1;
  localparam int unsigned RW   = MW + 1;
  localparam int unsigned SUMW = 2 * RW;
  localparam int unsigned SPW  = 3 * MW + 3;
  localparam int unsigned QW   = FB + 1;
  localparam int unsigned DPW  = 4;
  localparam int unsigned CMPW = (RW > LIMIT_W) ? RW : LIMIT_W;
  localparam int unsigned XW   = (QW > FIELD_W) ? QW : FIELD_W;

  // Limit register; the user must make writes only while the block is idle (unenforced).
  logic [LIMIT_W-1:0] limit_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // The whole pipeline advances together while the skid stage is empty.
  // A result that meets a stalled output parks in the skid stage, which
  // then freezes the pipeline and stalls the input.
  logic pipe_en;
  logic skid_valid_q;
  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Stage 1: take the low COORD_WIDTH bits of each field and form the edges.
  logic signed [CW-1:0] crd [9];
  logic signed [DW-1:0] edge_d [6];
  logic signed [DW-1:0] edge_q [6];
  logic                 v1_q;

  always_comb begin
    crd[0] = CW'(EW'($unsigned(in_data_i.ax)));
    crd[1] = CW'(EW'($unsigned(in_data_i.ay)));
    crd[2] = CW'(EW'($unsigned(in_data_i.az)));
    crd[3] = CW'(EW'($unsigned(in_data_i.bx)));
    crd[4] = CW'(EW'($unsigned(in_data_i.by)));
    crd[5] = CW'(EW'($unsigned(in_data_i.bz)));
    crd[6] = CW'(EW'($unsigned(in_data_i.cx)));
    crd[7] = CW'(EW'($unsigned(in_data_i.cy)));
    crd[8] = CW'(EW'($unsigned(in_data_i.cz)));
    for (int k = 0; k < 3; k++) begin
      edge_d[k]     = DW'(crd[k+3]) - DW'(crd[k]);
      edge_d[k + 3] = DW'(crd[k+6]) - DW'(crd[k]);
    end
  end

  // Stage 2: the six products of the cross product.
  // Order: uy*vz, uz*vy, uz*vx, ux*vz, ux*vy, uy*vx.
  logic signed [PRW-1:0] prod_q [6];
  logic                  v2_q;

  // Stage 3: cross product components, their magnitudes and signs.
  logic signed [NW-1:0] crs_d [3];
  logic [MW-1:0]        mag_d [3];
  logic [MW-1:0]        mag_q [3];
  logic [2:0]           sgn_q;
  logic                 v3_q;

  always_comb begin
    crs_d[0] = NW'(prod_q[0]) - NW'(prod_q[1]);
    crs_d[1] = NW'(prod_q[2]) - NW'(prod_q[3]);
    crs_d[2] = NW'(prod_q[4]) - NW'(prod_q[5]);
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = crs_d[k][NW-1] ? MW'(-crs_d[k]) : MW'(crs_d[k]);
    end
  end

  // Stage 4: squares; stage 5: their sum.
  logic [2*MW-1:0] sq_q [3];
  logic [MW-1:0]   mag4_q [3];
  logic [2:0]      sgn4_q;
  logic            v4_q;
  logic [SUMW-1:0] sum_q;
  logic [SPW-1:0]  pay5_q;
  logic            v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      edge_q    <= edge_d;
      prod_q[0] <= edge_q[1] * edge_q[5];
      prod_q[1] <= edge_q[2] * edge_q[4];
      prod_q[2] <= edge_q[2] * edge_q[3];
      prod_q[3] <= edge_q[0] * edge_q[5];
      prod_q[4] <= edge_q[0] * edge_q[4];
      prod_q[5] <= edge_q[1] * edge_q[3];
      mag_q     <= mag_d;
      sgn_q     <= {crs_d[2][NW-1], crs_d[1][NW-1], crs_d[0][NW-1]};
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= mag_q[k] * mag_q[k];
      end
      mag4_q    <= mag_q;
      sgn4_q    <= sgn_q;
      sum_q     <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
      pay5_q    <= {sgn4_q, mag4_q[2], mag4_q[1], mag4_q[0]};
    end
  end

  // Square root: one cell per root bit, most significant first.
  logic            sq_v   [RW+1];
  logic [SUMW-1:0] sq_rad [RW+1];
  logic [RW:0]     sq_rem [RW+1];
  logic [RW-1:0]   sq_root[RW+1];
  logic [SPW-1:0]  sq_pay [RW+1];

  assign sq_v[0]    = v5_q;
  assign sq_rad[0]  = sum_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = pay5_q;

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    tun_sqrt_cell #(.RW(RW), .PW(SPW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(sq_v[g]),
      .rad_i  (sq_rad[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .pay_i  (sq_pay[g]),
      .valid_o(sq_v[g+1]),
      .rad_o  (sq_rad[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .pay_o  (sq_pay[g+1])
    );
  end

  // Degeneracy test; the division cells then run on each magnitude.
  // As every magnitude is at most the root, the quotient needs FB+1 bits.
  logic            dg_v_q;
  logic [RW-1:0]   dg_len_q;
  logic [RW:0]     dg_rem_q [3];
  logic [DPW-1:0]  dg_pay_q;
  logic            degen_d;
  logic [RW-1:0]   len_d;
  logic [MW-1:0]   smag [3];
  logic [2:0]      ssgn;

  always_comb begin
    len_d   = sq_root[RW];
    {ssgn, smag[2], smag[1], smag[0]} = sq_pay[RW];
    degen_d = (len_d == '0) || (CMPW'(len_d) < CMPW'(limit_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dg_v_q <= 1'b0;
    end else if (pipe_en) begin
      dg_v_q <= sq_v[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dg_len_q <= len_d;
      dg_pay_q <= {degen_d, ssgn};
      for (int k = 0; k < 3; k++) begin
        dg_rem_q[k] <= (RW+1)'(smag[k]);
      end
    end
  end

  logic           dv_v   [QW+1];
  logic [RW-1:0]  dv_len [QW+1];
  logic [RW:0]    dv_rem [QW+1][3];
  logic [QW-1:0]  dv_quo [QW+1][3];
  logic [DPW-1:0] dv_pay [QW+1];

  assign dv_v[0]   = dg_v_q;
  assign dv_len[0] = dg_len_q;
  assign dv_rem[0] = dg_rem_q;
  assign dv_pay[0] = dg_pay_q;
  assign dv_quo[0] = '{default: '0};

  for (genvar g = 0; g < QW; g++) begin : g_div
    tun_div_cell #(.LW(RW), .QW(QW), .PW(DPW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(dv_v[g]),
      .len_i  (dv_len[g]),
      .rem_i  (dv_rem[g]),
      .quo_i  (dv_quo[g]),
      .pay_i  (dv_pay[g]),
      .valid_o(dv_v[g+1]),
      .len_o  (dv_len[g+1]),
      .rem_o  (dv_rem[g+1]),
      .quo_o  (dv_quo[g+1]),
      .pay_o  (dv_pay[g+1])
    );
  end

  // Result assembly: apply the signs, or give the default normal.
  tri_out_t      res_d;
  logic [XW-1:0] qx [3];
  logic [XW-1:0] one_x;

  always_comb begin
    one_x = XW'(1) << FB;
    for (int k = 0; k < 3; k++) begin
      qx[k] = XW'(dv_quo[QW][k]);
      if (dv_pay[QW][k]) begin
        qx[k] = -qx[k];
      end
    end
    if (dv_pay[QW][3]) begin
      res_d.norm_x     = '0;
      res_d.norm_y     = '0;
      res_d.norm_z     = FIELD_W'(one_x);
      res_d.degenerate = 1'b1;
    end else begin
      res_d.norm_x     = FIELD_W'(qx[0]);
      res_d.norm_y     = FIELD_W'(qx[1]);
      res_d.norm_z     = FIELD_W'(qx[2]);
      res_d.degenerate = 1'b0;
    end
  end

  // Output register and skid stage.
  logic     res_v;
  logic     out_valid_q;
  tri_out_t out_q;
  tri_out_t skid_q;
  logic     out_free;

  assign res_v    = dv_v[QW] && pipe_en;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_v;
      skid_valid_q <= 1'b0;
    end else if (res_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (res_v) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid stage is only ever full behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full with empty output register");

  // A result that meets a stalled output fills the skid stage.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_valid_q && out_valid_q && out_stall_i && res_v) |=> skid_valid_q)
    else $error("result dropped at stalled output");

  // A degenerate result carries the default normal.
  a_degen_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.norm_x == '0 && out_data_o.norm_y == '0))
    else $error("degenerate result with nonzero x or y");

endmodule

// ----- verif/tun_checker.sv -----
`timescale 1ns / 1ps

module tun_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  tun_pkg::tri_in_t            in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  tun_pkg::tri_out_t           out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [tun_pkg::LIMIT_W-1:0] cfg_data_i,
  output int                          errors_o,
  output int                          pending_o
);
  import tun_pkg::*;

  localparam int unsigned FRAC = 14;

  logic [LIMIT_W-1:0] deg_limit;
  tri_out_t           normal_q[$];
  int                 errors;

  assign errors_o  = errors;
  assign pending_o = normal_q.size();

  // Exact floor square root of a 128-bit sum of squares.
  function automatic logic [63:0] floor_root(input logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      sq   = 128'(cand) * 128'(cand);
      if (sq <= s) r = cand;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_comp(input longint n, input logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q   = (mag << FRAC) / len;
    if (n < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic tri_out_t predict_normal(input tri_in_t t);
    longint        ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0]  mx, my, mz;
    logic [127:0]  sum;
    logic [63:0]   len;
    tri_out_t      r;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    // The squares exceed 64 bits, so they are formed on 128-bit magnitudes.
    mx = (nx < 0) ? 128'(-nx) : 128'(nx);
    my = (ny < 0) ? 128'(-ny) : 128'(ny);
    mz = (nz < 0) ? 128'(-nz) : 128'(nz);
    sum = mx * mx + my * my + mz * mz;
    len = floor_root(sum);
    if (len == 0 || len < 64'(deg_limit)) begin
      r.norm_x     = '0;
      r.norm_y     = '0;
      r.norm_z     = 16'(1 << FRAC);
      r.degenerate = 1'b1;
    end else begin
      r.norm_x     = unit_comp(nx, len);
      r.norm_y     = unit_comp(ny, len);
      r.norm_z     = unit_comp(nz, len);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tri_out_t want;
    if (!rst_ni) begin
      deg_limit = 1;
      errors    = 0;
      normal_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) deg_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) normal_q.push_back(predict_normal(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (normal_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors++;
        end else begin
          want = normal_q.pop_front();
          if (out_data_i.norm_x !== want.norm_x)
            report_mismatch("norm_x", out_data_i.norm_x, want.norm_x);
          if (out_data_i.norm_y !== want.norm_y)
            report_mismatch("norm_y", out_data_i.norm_y, want.norm_y);
          if (out_data_i.norm_z !== want.norm_z)
            report_mismatch("norm_z", out_data_i.norm_z, want.norm_z);
          if (out_data_i.degenerate !== want.degenerate)
            report_mismatch("degenerate", 16'(out_data_i.degenerate), 16'(want.degenerate));
        end
      end
    end
  end

endmodule

// ----- verif/tb_triangle_unit_normal.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the triangle normal unit. All prediction and
// comparison lives in the checker instantiated beside the block.
module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int LATENCY = 57;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tri_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tri_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  int                 errors;
  int                 pending;

  // Idling probabilities in percent, changed per phase by the stimulus.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int hold_req = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_unit_normal uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  tun_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Receiver side. A hold-off request keeps the stall high for a long,
  // counted stretch so that the pipeline fills and pushes back on the input.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Generous watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one triangle, possibly after random idle cycles, and returns once
  // the beat has been taken. Valid is left high for a following beat.
  task automatic send_tri(input tri_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits first so that the last accepted beat is already counted.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // The limit is only rewritten with the pipeline empty.
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic tri_in_t mk_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_in_t t;
    t.ax = 16'(a0); t.ay = 16'(a1); t.az = 16'(a2);
    t.bx = 16'(b0); t.by = 16'(b1); t.bz = 16'(b2);
    t.cx = 16'(c0); t.cy = 16'(c1); t.cz = 16'(c2);
    return t;
  endfunction

  // Mix of full-range triangles, small ones whose length sits near typical
  // limits, collinear ones and ones with coincident vertices.
  function automatic tri_in_t rand_tri();
    tri_in_t t;
    int      kind;
    int      k;
    kind = $urandom_range(99);
    t = tri_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if (kind >= 40 && kind < 75) begin
      t.ax = 16'($urandom_range(127)) - 16'sd64;
      t.ay = 16'($urandom_range(127)) - 16'sd64;
      t.az = 16'($urandom_range(127)) - 16'sd64;
      t.bx = t.ax + 16'($urandom_range(63)) - 16'sd32;
      t.by = t.ay + 16'($urandom_range(63)) - 16'sd32;
      t.bz = t.az + 16'($urandom_range(63)) - 16'sd32;
      t.cx = t.ax + 16'($urandom_range(63)) - 16'sd32;
      t.cy = t.ay + 16'($urandom_range(63)) - 16'sd32;
      t.cz = t.az + 16'($urandom_range(63)) - 16'sd32;
    end else if (kind >= 75 && kind < 90) begin
      k = $urandom_range(6) - 3;
      t.bx = t.ax + 16'($urandom_range(255)) - 16'sd128;
      t.by = t.ay + 16'($urandom_range(255)) - 16'sd128;
      t.bz = t.az + 16'($urandom_range(255)) - 16'sd128;
      t.cx = t.ax + 16'(k) * (t.bx - t.ax);
      t.cy = t.ay + 16'(k) * (t.by - t.ay);
      t.cz = t.az + 16'(k) * (t.bz - t.az);
    end else if (kind >= 90) begin
      t.bx = t.ax; t.by = t.ay; t.bz = t.az;
    end
    return t;
  endfunction

  logic [LIMIT_W-1:0] limits [5];

  initial begin
    limits[0] = 1;                                   // reset value, not rewritten
    limits[1] = 0;                                   // only zero length is degenerate
    limits[2] = 3000;                                // catches many small triangles
    limits[3] = LIMIT_MAX;                           // everything degenerate
    limits[4] = LIMIT_W'({$urandom_range(3), $urandom});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed triangles under the reset limit, then again with a zero limit.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) write_limit(limits[1]);
      send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_tri(mk_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
      send_tri(mk_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
      send_tri(mk_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
      send_tri(mk_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
      send_tri(mk_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768));
      send_tri(mk_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767));
      send_tri(mk_tri(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767));
      send_tri(mk_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
      send_tri(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_tri(mk_tri(100, -50, 7, 100, -50, 7, 300, 9, -4));
    end

    // Random part: every limit setting but the reset one under every idling mix.
    for (int c = 1; c < 5; c++) begin
      if (c > 1) write_limit(limits[c]);
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
          default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
        for (int i = 0; i < 125; i++) begin
          if (c == 2 && m == 0 && i == 20) hold_req++;
          send_tri(rand_tri());
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
